>>> src/bump_region_allocator_defines.svh
// Assertion macros shared by the bump region allocator.
`ifndef BUMP_REGION_ALLOCATOR_DEFINES_SVH
`define BUMP_REGION_ALLOCATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BRA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bra_pkg.sv
// Types and constants shared by the bump region allocator.
package bra_pkg;

  // Width of a region offset; results carry one more bit to hold the full span
  localparam int OFFSET_BITS = 32;
  localparam int SPAN_W      = OFFSET_BITS + 1;
  localparam int EXT_W       = OFFSET_BITS + 2;

  // Configuration register widths and reset values
  localparam int REGION_W = 33;
  localparam int PSHIFT_W = 5;
  localparam logic [REGION_W-1:0] REGION_RESET = 33'h1_0000_0000;
  localparam logic [PSHIFT_W-1:0] PSHIFT_RESET = 5'd12;

  // Configuration register indexes
  localparam logic [0:0] CFG_REGION_SIZE = 1'b0;
  localparam logic [0:0] CFG_PAGE_SHIFT  = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_EXTEND = 2'd1,
    REQ_POP    = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_TOP   = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t              req_type;
    logic [OFFSET_BITS-1:0] block_offset;
    logic [OFFSET_BITS-1:0] size;
    logic [4:0]             align_log2;
    logic [OFFSET_BITS-1:0] prev_len;
    logic [OFFSET_BITS-1:0] next_len;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [OFFSET_BITS-1:0] alloc_offset;
    logic [SPAN_W-1:0]      commit_start;
    logic [SPAN_W-1:0]      commit_bytes;
    logic [SPAN_W-1:0]      used_bytes;
  } rsp_t;

  // Allocator state: bump offset and committed watermark
  typedef struct packed {
    logic [SPAN_W-1:0] used;
    logic [SPAN_W-1:0] committed;
  } state_t;

endpackage

>>> src/bra_step.sv
// Request evaluation: result and next allocator state for one transaction.
module bra_step (
  input  bra_pkg::state_t                  state,
  input  logic [bra_pkg::REGION_W-1:0]     region_size,
  input  logic [bra_pkg::PSHIFT_W-1:0]     page_shift,
  input  bra_pkg::req_t                    req,
  output bra_pkg::rsp_t                    rsp,
  output bra_pkg::state_t                  state_nxt
);

  localparam int OB    = bra_pkg::OFFSET_BITS;
  localparam int SW    = bra_pkg::SPAN_W;
  localparam int EW    = bra_pkg::EXT_W;
  localparam int RW    = bra_pkg::REGION_W;
  localparam int CMP_W = (RW > EW) ? RW : EW;

  logic [CMP_W-1:0] cap_wide;
  logic [EW-1:0]    cap;
  logic [EW-1:0]    limit;
  logic [EW-1:0]    used_ext;
  logic [EW-1:0]    align_m1;
  logic [EW-1:0]    aligned;
  logic [EW-1:0]    alloc_end;
  logic [EW-1:0]    blk_osz;
  logic [EW-1:0]    blk_sz;
  logic [EW-1:0]    ext_end;
  logic [EW-1:0]    new_end;
  logic [EW-1:0]    page_m1;
  logic [EW-1:0]    mark_raw;
  logic [EW-1:0]    mark;
  logic             do_adv;

  // Region limit, clipped to the addressable span
  always_comb begin
    cap_wide = CMP_W'(1) << OB;
    cap      = EW'(1) << OB;
    if (CMP_W'(region_size) > cap_wide) begin
      limit = cap;
    end else begin
      limit = EW'(CMP_W'(region_size));
    end
  end

  // Candidate ends for each request kind
  always_comb begin
    used_ext  = EW'(state.used);
    align_m1  = (EW'(1) << req.align_log2) - EW'(1);
    aligned   = (used_ext + align_m1) & ~align_m1;
    alloc_end = aligned + EW'(req.size);
    blk_osz   = EW'(req.block_offset) + EW'(req.prev_len);
    blk_sz    = EW'(req.block_offset) + EW'(req.size);
    ext_end   = EW'(req.block_offset) + EW'(req.next_len);
  end

  // Decode the request, then advance the bump offset and watermark
  always_comb begin
    rsp       = '0;
    rsp.status = bra_pkg::ST_OK;
    state_nxt = state;
    new_end   = '0;
    do_adv    = 1'b0;
    case (req.req_type)
      bra_pkg::REQ_ALLOC: begin
        if (aligned >= cap || alloc_end > limit) begin
          rsp.status = bra_pkg::ST_EXHAUSTED;
        end else begin
          rsp.alloc_offset = aligned[OB-1:0];
          new_end          = alloc_end;
          do_adv           = 1'b1;
        end
      end
      bra_pkg::REQ_EXTEND: begin
        if (blk_osz != used_ext) begin
          rsp.status = bra_pkg::ST_NOT_TOP;
        end else if (ext_end > limit) begin
          rsp.status = bra_pkg::ST_EXHAUSTED;
        end else begin
          new_end = ext_end;
          do_adv  = 1'b1;
        end
      end
      bra_pkg::REQ_POP: begin
        if (blk_sz != used_ext) begin
          rsp.status = bra_pkg::ST_NOT_TOP;
        end else begin
          state_nxt.used = SW'(req.block_offset);
        end
      end
      bra_pkg::REQ_QUERY: begin
        state_nxt = state;
      end
      default: begin
        state_nxt = state;
      end
    endcase

    // Round the new end up to a page and saturate at the full span
    page_m1  = (EW'(1) << page_shift) - EW'(1);
    mark_raw = (new_end + page_m1) & ~page_m1;
    mark     = (mark_raw > cap) ? cap : mark_raw;

    if (do_adv) begin
      state_nxt.used = new_end[SW-1:0];
      if (new_end > EW'(state.committed)) begin
        rsp.commit_start    = state.committed;
        rsp.commit_bytes    = mark[SW-1:0] - state.committed;
        state_nxt.committed = mark[SW-1:0];
      end
    end

    rsp.used_bytes = state_nxt.used;
  end

endmodule

>>> src/bump_region_allocator.sv
// Top level of the bump region allocator.
//
// Usage:
//   Requests arrive on the in_ channel (in_valid / in_stall / in_data) and one
//   result leaves on the out_ channel (out_valid / out_stall / out_data) for
//   every request, in order. A transaction moves at a rising edge with valid
//   high and stall low.
//   A taken request waits in the request register; its result then goes to
//   the result register and out_. Throughput: one request per clock while
//   out_stall is low; these two registers form two stages, so a new request is
//   taken while a finished result is still waiting at the output.
//   The state update (bump offset and watermark) happens as the result is
//   registered, so the following request already sees it.
//   When the receiver holds out_stall, the result stays put; in_stall rises
//   once the request register is also full, and drops as soon as the result
//   is taken.
//   Configuration: cfg_we with cfg_idx 0 writes the region size, index 1 the
//   page shift; write only while no request is in flight.
//   Reset (rst_n low, synchronous) empties both stages, clears the bump
//   offset and watermark, and restores a 4 GiB region with 4 KiB pages.
`include "bump_region_allocator_defines.svh"

module bump_region_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_idx,
  input  logic [bra_pkg::REGION_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bra_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bra_pkg::rsp_t                  out_data
);

  logic [bra_pkg::REGION_W-1:0] region_r;
  logic [bra_pkg::PSHIFT_W-1:0] pshift_r;
  bra_pkg::state_t              state_r;
  bra_pkg::state_t              state_nxt;
  logic                         s1_valid_r;
  bra_pkg::req_t                s1_req_r;
  logic                         out_valid_r;
  bra_pkg::rsp_t                out_data_r;
  bra_pkg::rsp_t                rsp;
  logic                         s1_advance;
  logic                         s1_go;
  logic                         in_go;

  // Handshake between the two stages
  assign s1_advance = !out_valid_r || !out_stall;
  assign s1_go      = s1_valid_r && s1_advance;
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_go      = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= bra_pkg::REGION_RESET;
      pshift_r <= bra_pkg::PSHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        bra_pkg::CFG_REGION_SIZE: region_r <= cfg_wdata;
        bra_pkg::CFG_PAGE_SHIFT:  pshift_r <= cfg_wdata[bra_pkg::PSHIFT_W-1:0];
        default:                  region_r <= region_r;
      endcase
    end
  end

  // Request register: fill on a new transaction, empty once it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_go) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_req_r <= in_data;
    end
  end

  // Evaluate the held request against the current state
  bra_step u_step (
    .state       (state_r),
    .region_size (region_r),
    .page_shift  (pshift_r),
    .req         (s1_req_r),
    .rsp         (rsp),
    .state_nxt   (state_nxt)
  );

  // Commit the state as the result is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= rsp;
    end
  end

  // Checks on the allocator state
  `BRA_ASSERT_SAME(a_mark_covers_used, 1'b1, state_r.used <= state_r.committed,
                   "watermark below bump offset")
  `BRA_ASSERT_NEXT(a_mark_monotonic, 1'b1, state_r.committed >= $past(state_r.committed),
                   "watermark fell")
  `BRA_ASSERT_NEXT(a_fail_keeps_state, s1_go && rsp.status != bra_pkg::ST_OK,
                   $stable(state_r), "state changed on a refused request")

endmodule
